// ===== sv/cas_pkg.sv =====
// Package for the cassette tape bit decoder: payload structs, divider
// handshake structs, sequencer states and register indexes. No dependencies.
`default_nettype none

package cas_pkg;

    localparam int MAX_HEADER_BYTES = 8;
    localparam int COUNT_BITS       = 16;
    localparam int RATE_BITS        = 18;
    localparam int HDR_BITS         = 8 * MAX_HEADER_BYTES;
    localparam int CFG_INDEX_BITS   = 4;
    localparam int DIV_CNT_BITS     = $clog2(RATE_BITS + 1);

    typedef struct packed {
        logic        command;
        logic [15:0] chan_a;
        logic [15:0] chan_b;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } out_item_t;

    typedef struct packed {
        logic                  start;
        logic [RATE_BITS-1:0]  dividend;
        logic [COUNT_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [RATE_BITS-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_DECIDE = 3'b100
    } seq_state_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SIXTEEN_BIT    = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEREO         = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_RATE    = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD      = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ONE_IS_LOW     = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MSB_FIRST      = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_PATTERN = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_BYTES   = 4'd7;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

endpackage

`default_nettype wire

// ===== sv/cas_mix.sv =====
// Mixes one PCM frame (8-bit unsigned or 16-bit signed, mono or stereo)
// down to one signed 16-bit sample. Purely combinational; no dependencies.
`default_nettype none

module cas_mix (
    input  wire logic [15:0]        chan_a,
    input  wire logic [15:0]        chan_b,
    input  wire logic               sixteen_bit,
    input  wire logic               stereo,
    output logic signed [15:0]      sample
);

    logic signed [7:0]  a8;
    logic signed [7:0]  b8;
    logic signed [8:0]  sum8;
    logic signed [15:0] a16;
    logic signed [15:0] b16;
    logic signed [15:0] a_half;
    logic signed [15:0] b_half;
    logic signed [16:0] sum16;

    // Flipping the top bit of an unsigned byte subtracts 128.
    assign a8   = {~chan_a[7], chan_a[6:0]};
    assign b8   = {~chan_b[7], chan_b[6:0]};
    assign sum8 = {a8[7], a8} + {b8[7], b8};

    assign a16 = chan_a;
    assign b16 = chan_b;

    // Halving must round toward zero, so odd negative values get one added back.
    assign a_half = (a16 >>> 1) + $signed({15'd0, a16[15] & a16[0]});
    assign b_half = (b16 >>> 1) + $signed({15'd0, b16[15] & b16[0]});
    assign sum16  = {a_half[15], a_half} + {b_half[15], b_half};

    always_comb
    begin
        if (!sixteen_bit)
        begin
            if (!stereo)
                sample = {a8, 8'd0};
            else
                sample = {sum8, 7'd0};
        end
        else
        begin
            if (!stereo)
                sample = a16;
            else
                sample = sum16[15:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/cas_div.sv =====
// Restoring serial divider, one quotient bit per cycle, used to turn the
// cycle count into a frequency. Depends on cas_pkg.
`default_nettype none

module cas_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cas_pkg::div_req_t req,
    output cas_pkg::div_rsp_t    rsp
);

    logic                                  busy_reg;
    logic                                  busy_next;
    logic [cas_pkg::DIV_CNT_BITS-1:0]      cnt_reg;
    logic [cas_pkg::DIV_CNT_BITS-1:0]      cnt_next;
    logic [cas_pkg::RATE_BITS-1:0]         quo_reg;
    logic [cas_pkg::RATE_BITS-1:0]         quo_next;
    logic [cas_pkg::COUNT_BITS-1:0]        rem_reg;
    logic [cas_pkg::COUNT_BITS-1:0]        rem_next;
    logic [cas_pkg::COUNT_BITS-1:0]        dvsr_reg;
    logic [cas_pkg::COUNT_BITS-1:0]        dvsr_next;
    logic [cas_pkg::COUNT_BITS:0]          shifted;
    logic [cas_pkg::COUNT_BITS:0]          diff;
    logic                                  fits;

    assign shifted = {rem_reg, quo_reg[cas_pkg::RATE_BITS-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};
    assign fits    = shifted >= {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cas_pkg::DIV_CNT_BITS'(cas_pkg::RATE_BITS);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
                quo_next = {quo_reg[cas_pkg::RATE_BITS-2:0], fits};
                rem_next = fits ? diff[cas_pkg::COUNT_BITS-1:0]
                                : shifted[cas_pkg::COUNT_BITS-1:0];
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done     = busy_reg && (cnt_reg == '0);
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/cassette_tape_bit_decoder.sv =====
// Cassette FSK decoder: times rising zero crossings of a PCM stream, makes
// one bit per crossing, hunts for a sync header and then assembles bytes.
// Depends on cas_pkg, cas_mix and cas_div.
//
// A restart command, or a sample frame that is not a rising zero crossing,
// is handled in ST_IDLE alone. A crossing frame is accepted in ST_IDLE,
// which starts the serial divider that computes sample_rate / count; ST_DIV
// waits through the divider's iterations and its completion, and ST_DECIDE
// decides the bit and updates the header or byte register; it waits while
// a previous result is still held in the output register. The block raises
// in_stall while it works on a crossing. Results leave through a registered
// output, so a new frame can be taken while a result waits. Configuration
// writes are always taken and must only be issued while the block is idle.
`default_nettype none

module cassette_tape_bit_decoder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire cas_pkg::in_item_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output cas_pkg::out_item_t                       out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [cas_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [63:0]                         cfg_data
);

    localparam int HB = cas_pkg::HDR_BITS;
    localparam int MB = cas_pkg::MAX_HEADER_BYTES;

    // Configuration registers.
    logic                            sixteen_bit_reg;
    logic                            stereo_reg;
    logic [cas_pkg::RATE_BITS-1:0]   sample_rate_reg;
    logic [cas_pkg::RATE_BITS-1:0]   threshold_reg;
    logic                            one_is_low_reg;
    logic                            msb_first_reg;
    logic [HB-1:0]                   header_pattern_reg;
    logic [3:0]                      header_bytes_reg;

    // Decoder state.
    cas_pkg::seq_state_t             state_reg;
    cas_pkg::seq_state_t             state_next;
    logic signed [15:0]              prev_sample_reg;
    logic signed [15:0]              prev_sample_next;
    logic [cas_pkg::COUNT_BITS-1:0]  cycle_count_reg;
    logic [cas_pkg::COUNT_BITS-1:0]  cycle_count_next;
    logic                            hunting_reg;
    logic                            hunting_next;
    logic [HB-1:0]                   header_shift_reg;
    logic [HB-1:0]                   header_shift_next;
    logic [7:0]                      byte_shift_reg;
    logic [7:0]                      byte_shift_next;
    logic [2:0]                      bit_index_reg;
    logic [2:0]                      bit_index_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    cas_pkg::out_item_t              out_data_reg;
    cas_pkg::out_item_t              out_data_next;

    logic signed [15:0]              sample;
    logic                            crossed;
    logic [cas_pkg::COUNT_BITS-1:0]  count_inc;
    logic                            accept;
    cas_pkg::div_req_t               div_req;
    cas_pkg::div_rsp_t               div_rsp;

    logic [3:0]                      used_bytes;
    logic [HB-1:0]                   used_mask;
    logic [HB-1:0]                   hdr_cur;
    logic [HB-1:0]                   hdr_shifted;
    logic [HB-1:0]                   hdr_new;
    logic                            hdr_match;
    logic                            new_bit;
    logic [7:0]                      byte_new;
    logic [2:0]                      index_new;
    logic                            out_free;

    cas_mix u_mix (
        .chan_a      (in_data.chan_a),
        .chan_b      (in_data.chan_b),
        .sixteen_bit (sixteen_bit_reg),
        .stereo      (stereo_reg),
        .sample      (sample)
    );

    cas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != cas_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign crossed   = prev_sample_reg[15] && !sample[15];
    assign count_inc = (&cycle_count_reg) ? cycle_count_reg : cycle_count_reg + 1'b1;

    assign div_req.start    = accept && !in_data.command && crossed;
    assign div_req.dividend = sample_rate_reg;
    assign div_req.divisor  = count_inc;

    // Header length is clamped to the supported range.
    always_comb
    begin
        if (header_bytes_reg == 4'd0)
            used_bytes = 4'd1;
        else if (header_bytes_reg > 4'(MB))
            used_bytes = 4'(MB);
        else
            used_bytes = header_bytes_reg;
    end

    always_comb
    begin
        for (int k = 0; k < MB; k++)
            used_mask[8*k +: 8] = (4'(k) < used_bytes) ? 8'hFF : 8'h00;
    end

    assign hdr_cur = header_shift_reg & used_mask;

    // Least significant first: each byte shifts right, and its low bit
    // carries into the top of the next more significant byte.
    always_comb
    begin
        hdr_shifted[7:0] = {new_bit, hdr_cur[7:1]};
        for (int k = 1; k < MB; k++)
            hdr_shifted[8*k +: 8] = {hdr_cur[8*k-8], hdr_cur[8*k+1 +: 7]};
    end

    always_comb
    begin
        if (msb_first_reg)
            hdr_new = {hdr_cur[HB-2:0], new_bit} & used_mask;
        else
            hdr_new = hdr_shifted & used_mask;
    end

    assign hdr_match = (hdr_new == (header_pattern_reg & used_mask));

    assign new_bit = one_is_low_reg ? (threshold_reg > div_rsp.quotient)
                                    : (threshold_reg <= div_rsp.quotient);
    assign byte_new  = msb_first_reg ? {byte_shift_reg[6:0], new_bit}
                                     : {new_bit, byte_shift_reg[7:1]};
    assign index_new = bit_index_reg + 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next        = state_reg;
        prev_sample_next  = prev_sample_reg;
        cycle_count_next  = cycle_count_reg;
        hunting_next      = hunting_reg;
        header_shift_next = header_shift_reg;
        byte_shift_next   = byte_shift_reg;
        bit_index_next    = bit_index_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_data_next     = out_data_reg;

        unique case (state_reg)
            cas_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.command)
                    begin
                        hunting_next      = 1'b1;
                        header_shift_next = '0;
                        byte_shift_next   = '0;
                        bit_index_next    = '0;
                    end
                    else
                    begin
                        prev_sample_next = sample;
                        if (crossed)
                        begin
                            cycle_count_next = '0;
                            state_next       = cas_pkg::ST_DIV;
                        end
                        else
                        begin
                            cycle_count_next = count_inc;
                        end
                    end
                end
            end
            cas_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = cas_pkg::ST_DECIDE;
            end
            cas_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = cas_pkg::ST_IDLE;
                    if (hunting_reg)
                    begin
                        header_shift_next = hdr_new;
                        if (hdr_match)
                        begin
                            hunting_next            = 1'b0;
                            byte_shift_next         = '0;
                            bit_index_next          = '0;
                            out_valid_next          = 1'b1;
                            out_data_next.kind      = cas_pkg::KIND_HEADER;
                            out_data_next.data_byte = '0;
                        end
                    end
                    else
                    begin
                        bit_index_next = index_new;
                        if (index_new == 3'd0)
                        begin
                            byte_shift_next         = '0;
                            out_valid_next          = 1'b1;
                            out_data_next.kind      = cas_pkg::KIND_DATA;
                            out_data_next.data_byte = byte_new;
                        end
                        else
                        begin
                            byte_shift_next = byte_new;
                        end
                    end
                end
            end
            default:
            begin
                state_next = cas_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cas_pkg::ST_IDLE;
            prev_sample_reg  <= '0;
            cycle_count_reg  <= '0;
            hunting_reg      <= 1'b1;
            header_shift_reg <= '0;
            byte_shift_reg   <= '0;
            bit_index_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prev_sample_reg  <= prev_sample_next;
            cycle_count_reg  <= cycle_count_next;
            hunting_reg      <= hunting_next;
            header_shift_reg <= header_shift_next;
            byte_shift_reg   <= byte_shift_next;
            bit_index_reg    <= bit_index_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sixteen_bit_reg    <= 1'b0;
            stereo_reg         <= 1'b0;
            sample_rate_reg    <= 18'd44100;
            threshold_reg      <= 18'd1800;
            one_is_low_reg     <= 1'b0;
            msb_first_reg      <= 1'b1;
            header_pattern_reg <= '0;
            header_bytes_reg   <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cas_pkg::REG_SIXTEEN_BIT:    sixteen_bit_reg    <= cfg_data[0];
                cas_pkg::REG_STEREO:         stereo_reg         <= cfg_data[0];
                cas_pkg::REG_SAMPLE_RATE:    sample_rate_reg    <= cfg_data[17:0];
                cas_pkg::REG_THRESHOLD:      threshold_reg      <= cfg_data[17:0];
                cas_pkg::REG_ONE_IS_LOW:     one_is_low_reg     <= cfg_data[0];
                cas_pkg::REG_MSB_FIRST:      msb_first_reg      <= cfg_data[0];
                cas_pkg::REG_HEADER_PATTERN: header_pattern_reg <= cfg_data[HB-1:0];
                cas_pkg::REG_HEADER_BYTES:   header_bytes_reg   <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== tb/cassette_tape_bit_decoder_test.sv =====
// Self-checking testbench for cassette_tape_bit_decoder: frames are fed through a
// bursty valid/stall sender and checked against an in-bench decoder model.
// Depends on cas_pkg and the cassette_tape_bit_decoder RTL.

module cassette_tape_bit_decoder_test;

    localparam int  HALF_PERIOD  = 5;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  QUIET_LIMIT  = 4000;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  RANDOM_ITEMS = 1800;
    localparam logic CMD_FRAME   = 1'b0;
    localparam logic CMD_RESTART = 1'b1;
    localparam logic [cas_pkg::COUNT_BITS-1:0] COUNT_MAX = {cas_pkg::COUNT_BITS{1'b1}};

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_stall;
    cas_pkg::in_item_t                  in_data   = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    cas_pkg::out_item_t                 out_data;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [cas_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [63:0]                        cfg_data  = '0;

    // Register copies, updated when the block takes a write.
    logic        cfg_sixteen    = 1'b0;
    logic        cfg_stereo     = 1'b0;
    logic [17:0] cfg_rate       = 18'd44100;
    logic [17:0] cfg_threshold  = 18'd1800;
    logic        cfg_one_is_low = 1'b0;
    logic        cfg_msb_first  = 1'b1;
    logic [63:0] cfg_pattern    = '0;
    logic [3:0]  cfg_hdr_len    = 4'd1;

    // Decoder state as the block should hold it.
    int                             prev_level   = 0;
    logic [cas_pkg::COUNT_BITS-1:0] run_length   = '0;
    logic                           hunting      = 1'b1;
    logic [63:0]                    sync_shift   = '0;
    logic [7:0]                     byte_acc     = '0;
    logic [2:0]                     bits_in_byte = '0;

    cas_pkg::in_item_t  frame_q[$];
    cas_pkg::out_item_t expected_decodes[$];
    cas_pkg::out_item_t oldest;
    int          items_made   = 0;
    int          results_seen = 0;
    int          fail_count   = 0;
    int          quiet_cycles = 0;
    logic        item_taken   = 1'b0;
    int          gap_left     = 0;
    int          burst_left   = 1;
    bit          long_hold_req = 1'b0;
    int          hold_left    = 0;
    int          mode_left    = 0;
    stall_mode_t stall_mode   = STALL_NONE;

    cassette_tape_bit_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int mix_frame(logic [15:0] a, logic [15:0] b);
        int x;
        int y;
        if (!cfg_sixteen)
        begin
            // 8-bit samples are offset binary around 0x80.
            x = int'(a[7:0]) - 128;
            y = int'(b[7:0]) - 128;
            return cfg_stereo ? (x + y) * 128 : x * 256;
        end
        x = int'($signed(a));
        y = int'($signed(b));
        return cfg_stereo ? x / 2 + y / 2 : x;
    endfunction

    function automatic logic pulse_bit(int unsigned count);
        int unsigned freq;
        freq = (count != 0) ? 32'(cfg_rate) / count : 0;
        if (cfg_one_is_low)
            return 32'(cfg_threshold) > freq;
        return 32'(cfg_threshold) <= freq;
    endfunction

    function automatic int header_len();
        if (cfg_hdr_len == 4'd0)
            return 1;
        if (int'(cfg_hdr_len) > cas_pkg::MAX_HEADER_BYTES)
            return cas_pkg::MAX_HEADER_BYTES;
        return int'(cfg_hdr_len);
    endfunction

    task automatic decode_frame(cas_pkg::in_item_t it);
        int                 level;
        int                 n;
        int                 k;
        logic               b;
        logic               carry;
        logic               spill;
        logic [7:0]         lane;
        logic [63:0]        hmask;
        logic [63:0]        cur;
        logic [63:0]        nxt;
        cas_pkg::out_item_t res;
        if (it.command == CMD_RESTART)
        begin
            hunting      = 1'b1;
            sync_shift   = '0;
            byte_acc     = '0;
            bits_in_byte = '0;
            return;
        end
        level = mix_frame(it.chan_a, it.chan_b);
        b = (prev_level < 0) && (level >= 0);
        prev_level = level;
        if (run_length != COUNT_MAX)
            run_length = run_length + 1'b1;
        if (!b)
            return;
        b = pulse_bit(32'(run_length));
        run_length = '0;
        if (hunting)
        begin
            // The header register is a chain of bytes; the new bit enters the
            // lowest byte and each byte passes its outgoing bit to the one above.
            n = header_len();
            hmask = (n >= 8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
            cur = sync_shift & hmask;
            nxt = '0;
            carry = b;
            for (k = 0; k < n; k++)
            begin
                lane = cur[8 * k +: 8];
                if (cfg_msb_first)
                begin
                    spill = lane[7];
                    lane = {lane[6:0], carry};
                end
                else
                begin
                    spill = lane[0];
                    lane = {carry, lane[7:1]};
                end
                carry = spill;
                nxt[8 * k +: 8] = lane;
            end
            sync_shift = nxt;
            if (nxt == (cfg_pattern & hmask))
            begin
                hunting        = 1'b0;
                byte_acc       = '0;
                bits_in_byte   = '0;
                res.kind       = cas_pkg::KIND_HEADER;
                res.data_byte  = '0;
                expected_decodes.push_back(res);
            end
            return;
        end
        byte_acc = cfg_msb_first ? {byte_acc[6:0], b} : {b, byte_acc[7:1]};
        bits_in_byte = bits_in_byte + 3'd1;
        if (bits_in_byte == 3'd0)
        begin
            res.kind      = cas_pkg::KIND_DATA;
            res.data_byte = byte_acc;
            expected_decodes.push_back(res);
            byte_acc = '0;
        end
    endtask

    // Monitor: predicts on every accepted frame and checks every accepted result.
    always @(posedge clk)
    begin
        item_taken <= in_valid && !in_stall;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cas_pkg::REG_SIXTEEN_BIT:    cfg_sixteen    = cfg_data[0];
                cas_pkg::REG_STEREO:         cfg_stereo     = cfg_data[0];
                cas_pkg::REG_SAMPLE_RATE:    cfg_rate       = cfg_data[17:0];
                cas_pkg::REG_THRESHOLD:      cfg_threshold  = cfg_data[17:0];
                cas_pkg::REG_ONE_IS_LOW:     cfg_one_is_low = cfg_data[0];
                cas_pkg::REG_MSB_FIRST:      cfg_msb_first  = cfg_data[0];
                cas_pkg::REG_HEADER_PATTERN: cfg_pattern    = cfg_data;
                cas_pkg::REG_HEADER_BYTES:   cfg_hdr_len    = cfg_data[3:0];
                default: ;
            endcase
        end
        if (rst_n && in_valid && !in_stall)
            decode_frame(in_data);
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_decodes.size() == 0)
            begin
                $error("unexpected result: kind %0d data_byte 0x%02h",
                       out_data.kind, out_data.data_byte);
                fail_count++;
            end
            else
            begin
                oldest = expected_decodes.pop_front();
                if (out_data.kind !== oldest.kind)
                begin
                    $error("kind: expected %0d, got %0d", oldest.kind, out_data.kind);
                    fail_count++;
                end
                if (out_data.data_byte !== oldest.data_byte)
                begin
                    $error("data_byte: expected 0x%02h, got 0x%02h",
                           oldest.data_byte, out_data.data_byte);
                    fail_count++;
                end
            end
        end
    end

    // Driver: offers queued frames in bursts separated by random gaps.
    always @(negedge clk)
    begin
        if (!in_valid || item_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (frame_q.size() != 0)
            begin
                in_data  <= frame_q.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side: changes its stall pattern now and then, and holds off for
    // a long stretch when asked.
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            hold_left     = HOLD_CYCLES;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                default:     out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_item(cas_pkg::in_item_t it);
        frame_q.push_back(it);
        items_made++;
    endtask

    task automatic push_raw(logic cmd, logic [15:0] a, logic [15:0] b);
        cas_pkg::in_item_t it;
        it.command = cmd;
        it.chan_a  = a;
        it.chan_b  = b;
        push_item(it);
    endtask

    function automatic cas_pkg::in_item_t make_frame(logic neg);
        cas_pkg::in_item_t it;
        it.command = CMD_FRAME;
        do
        begin
            it.chan_a = 16'($urandom);
            it.chan_b = 16'($urandom);
        end
        while ((mix_frame(it.chan_a, it.chan_b) < 0) != neg);
        return it;
    endfunction

    function automatic cas_pkg::in_item_t make_restart();
        cas_pkg::in_item_t it;
        it.command = CMD_RESTART;
        it.chan_a  = 16'($urandom);
        it.chan_b  = 16'($urandom);
        return it;
    endfunction

    // Tries random crossing distances for one that decodes to the wanted bit, else picks a short one.
    function automatic int pick_count(logic b);
        int c;
        int t;
        for (t = 0; t < 32; t++)
        begin
            c = (t < 20) ? $urandom_range(2, 7) : $urandom_range(2, 40);
            if (pulse_bit(c) == b)
                return c;
        end
        return $urandom_range(2, 7);
    endfunction

    // One cycle of c frames: high, then low, then the rising crossing.
    task automatic push_pulse(int c);
        int h;
        h = $urandom_range(0, c - 2);
        repeat (h) push_item(make_frame(1'b0));
        repeat (c - 1 - h) push_item(make_frame(1'b1));
        push_item(make_frame(1'b0));
    endtask

    // A block on tape: resync crossing, restart, sync header, then data bits.
    // Some are line noise and some carry a corrupted header.
    task automatic push_record();
        int   sel;
        int   n;
        int   j;
        int   pos;
        int   flip_at;
        int   nbits;
        logic b;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            repeat ($urandom_range(5, 30))
            begin
                if ($urandom_range(0, 7) == 0)
                    push_item(make_restart());
                else
                    push_item(make_frame(1'($urandom_range(0, 1))));
            end
            return;
        end
        push_item(make_frame(1'b1));
        push_item(make_frame(1'b0));
        push_item(make_restart());
        n = header_len();
        flip_at = (sel == 1) ? $urandom_range(0, 8 * n - 1) : -1;
        for (j = 0; j < 8 * n; j++)
        begin
            pos = 8 * (n - 1 - j / 8) + (cfg_msb_first ? 7 - j % 8 : j % 8);
            b = cfg_pattern[pos] ^ (j == flip_at);
            push_pulse(pick_count(b));
        end
        nbits = 8 * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0)
            nbits += $urandom_range(1, 7);
        repeat (nbits) push_pulse(pick_count(1'($urandom_range(0, 1))));
    endtask

    task automatic write_reg(logic [cas_pkg::CFG_INDEX_BITS-1:0] idx, logic [63:0] value,
                             int width);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        // Bits above the register width must be dropped by the block.
        if (width < 64 && $urandom_range(0, 1))
            value = value | (junk << width);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic s16, logic st, logic [17:0] rate, logic [17:0] thr,
                             logic oil, logic msb, logic [63:0] pat, logic [3:0] hb);
        logic [cas_pkg::CFG_INDEX_BITS-1:0] stray;
        write_reg(cas_pkg::REG_SIXTEEN_BIT, 64'(s16), 1);
        write_reg(cas_pkg::REG_STEREO, 64'(st), 1);
        write_reg(cas_pkg::REG_SAMPLE_RATE, 64'(rate), 18);
        write_reg(cas_pkg::REG_THRESHOLD, 64'(thr), 18);
        write_reg(cas_pkg::REG_ONE_IS_LOW, 64'(oil), 1);
        write_reg(cas_pkg::REG_MSB_FIRST, 64'(msb), 1);
        write_reg(cas_pkg::REG_HEADER_PATTERN, pat, 64);
        write_reg(cas_pkg::REG_HEADER_BYTES, 64'(hb), 4);
        if ($urandom_range(0, 1))
        begin
            stray = cas_pkg::REG_HEADER_BYTES + 4'd1 + 4'($urandom_range(0, 7));
            write_reg(stray, {$urandom, $urandom}, 64);
        end
    endtask

    // Waits until every frame is taken and every result has come back, then
    // lets a crossing that yields no result finish before anything else.
    task automatic settle();
        while (frame_q.size() != 0 || in_valid || expected_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int          phase_no;
        int          target;
        int          hb_pick;
        int          split;
        logic        oil;
        logic [17:0] rate;
        logic [3:0]  hb;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings, 8-bit mono: sign boundary and a crossing spanning a restart.
        push_raw(CMD_FRAME, 16'h0000, 16'h0000);
        push_raw(CMD_FRAME, 16'hFF80, 16'hFFFF);
        push_raw(CMD_FRAME, 16'h007F, 16'hFFFF);
        push_raw(CMD_RESTART, 16'hFFFF, 16'hFFFF);
        push_raw(CMD_FRAME, 16'h00FF, 16'h0000);
        settle();

        // 16-bit stereo: halves truncate toward zero.
        write_all(1'b1, 1'b1, 18'd1200, 18'd400, 1'b0, 1'b1, 64'hA5, 4'd1);
        push_raw(CMD_FRAME, 16'h8000, 16'h8000);
        push_raw(CMD_FRAME, 16'hFFFF, 16'h0001);
        push_raw(CMD_FRAME, 16'h7FFF, 16'h8000);
        push_raw(CMD_FRAME, 16'h0001, 16'hFFFF);
        push_raw(CMD_FRAME, 16'h8001, 16'h7FFF);
        settle();

        write_all(1'b1, 1'b0, 18'd1200, 18'd400, 1'b0, 1'b1, 64'hA5, 4'd1);
        push_raw(CMD_FRAME, 16'h8000, 16'h0000);
        push_raw(CMD_FRAME, 16'h7FFF, 16'hFFFF);
        push_raw(CMD_FRAME, 16'hFFFF, 16'h0000);
        push_raw(CMD_FRAME, 16'h0000, 16'hFFFF);
        settle();

        write_all(1'b0, 1'b1, 18'd1200, 18'd400, 1'b0, 1'b1, 64'hA5, 4'd1);
        push_raw(CMD_FRAME, 16'h0000, 16'h0000);
        push_raw(CMD_FRAME, 16'h00FF, 16'h0001);
        push_raw(CMD_FRAME, 16'h007F, 16'h0080);
        push_raw(CMD_FRAME, 16'h00FF, 16'h00FF);
        settle();

        // Zero sample rate: every bit decodes to one; a zero length acts as one byte.
        write_all(1'b0, 1'b1, 18'd0, 18'd0, 1'b0, 1'b1, {64{1'b1}}, 4'd0);
        repeat (3) push_record();
        settle();

        // Largest threshold against largest rate, oversized header length.
        write_all(1'b1, 1'b0, 18'h3FFFF, 18'h3FFFF, 1'b1, 1'b0, {64{1'b1}}, 4'd15);
        push_record();
        settle();

        // Largest rate with a two-byte random header.
        write_all(1'b1, 1'b1, 18'h3FFFF, 18'd74898, 1'b0, 1'b1,
                  {$urandom, $urandom}, 4'd2);
        push_item(make_frame(1'b1));
        push_item(make_frame(1'b0));
        repeat (3) push_record();
        settle();

        phase_no = 0;
        while (phase_no == 0 || (items_made < RANDOM_ITEMS && phase_no < 40))
        begin
            oil  = 1'($urandom_range(0, 1));
            rate = ($urandom_range(0, 3) == 0) ? 18'($urandom_range(1, 100))
                                               : 18'($urandom_range(1000, 262143));
            split = $urandom_range(2, 6);
            hb_pick = $urandom_range(0, 9);
            if (phase_no == 0 || hb_pick < 6)
                hb = 4'($urandom_range(1, 2));
            else if (hb_pick < 8)
                hb = 4'($urandom_range(3, 8));
            else if (hb_pick == 8)
                hb = 4'd0;
            else
                hb = 4'($urandom_range(9, 15));
            write_all(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rate,
                      rate / 18'(split), oil, 1'($urandom_range(0, 1)),
                      {$urandom, $urandom}, hb);
            target = items_made + $urandom_range(120, 260);
            while (items_made < target)
                push_record();
            // The first phase also backs up the block behind a stalled receiver.
            if (phase_no == 0)
                long_hold_req = 1'b1;
            settle();
            phase_no++;
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
sv/cas_pkg.sv
sv/cas_mix.sv
sv/cas_div.sv
sv/cassette_tape_bit_decoder.sv
tb/cassette_tape_bit_decoder_test.sv
